[hw/rtl/bol_pkg.sv]
// shared types, constants and codes for the bounded ordered list
package bol_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W    = 6;
  localparam int unsigned CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic signed [31:0] elem_t;

  typedef enum logic [2:0] {
    CMD_INS_POS  = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_INS_SORT = 3'd2,
    CMD_DEL_POS  = 3'd3,
    CMD_DEL_TAIL = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INS_POS,
    OP_INS_SORT,
    OP_DEL
  } cell_op_e;

  typedef struct packed {
    logic [2:0]       command;
    elem_t            value;
    logic [POS_W-1:0] position;
  } cmd_t;

  typedef struct packed {
    elem_t      removed_value;
    logic       removed_valid;
    logic [1:0] status;
    logic [5:0] element_count;
  } res_t;

  typedef struct packed {
    cell_op_e         op;
    logic [IDX_W-1:0] tgt;
    elem_t            value;
    logic [CNT_W-1:0] count;
  } cell_ctl_t;

endpackage

[hw/rtl/bol_cell.sv]
// one list slot: holds an entry, shifts with its neighbors on insert and delete
module bol_cell (
  input  logic                     clk_i,
  input  bol_pkg::cell_ctl_t       ctl_i,
  input  logic [bol_pkg::IDX_W-1:0] slot_i,
  input  bol_pkg::elem_t           left_i,
  input  bol_pkg::elem_t           right_i,
  input  logic                     run_i,
  input  bol_pkg::elem_t           rem_i,
  output bol_pkg::elem_t           data_o,
  output logic                     run_o,
  output bol_pkg::elem_t           rem_o
);

  bol_pkg::elem_t data_q;
  bol_pkg::elem_t data_d;
  logic           occupied;
  logic           less;

  assign occupied = bol_pkg::CNT_W'(slot_i) < ctl_i.count;
  assign less     = occupied && (data_q < ctl_i.value);
  assign run_o    = run_i & less;
  assign data_o   = data_q;
  assign rem_o    = rem_i | (((ctl_i.op == bol_pkg::OP_DEL) && (slot_i == ctl_i.tgt))
                             ? data_q : '0);

  always_comb begin
    data_d = data_q;
    case (ctl_i.op)
      bol_pkg::OP_INS_POS: begin
        if (slot_i > ctl_i.tgt) begin
          data_d = left_i;
        end else if (slot_i == ctl_i.tgt) begin
          data_d = ctl_i.value;
        end
      end
      bol_pkg::OP_INS_SORT: begin
        if (!run_i) begin
          data_d = left_i;
        end else if (!less) begin
          data_d = ctl_i.value;
        end
      end
      bol_pkg::OP_DEL: begin
        if (slot_i >= ctl_i.tgt) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

[hw/rtl/bounded_ordered_list_core.sv]
// top level of the bounded ordered list: command decode, cell row and result register
//
// channel   direction  handshake               word
// command   in         start & !busy           cmd_i (bol_pkg::cmd_t)
// result    out        done_o, one cycle       result_o (bol_pkg::res_t)
//
// the cell row updates on acceptance; the result register shows it in the next cycle
// busy stays low, so a command can be issued on every cycle
// all slots compare and shift in parallel, the removed entry ripples out along the row
// reset clears the element count; slot contents need no reset
// the receiver cannot stall; done_o marks each result for a single cycle
module bounded_ordered_list_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  bol_pkg::cmd_t cmd_i,
  output logic          busy,
  output logic          done_o,
  output bol_pkg::res_t result_o
);

  logic                       accept;
  logic [bol_pkg::CNT_W-1:0]  count_q;
  logic [bol_pkg::CNT_W-1:0]  count_d;
  logic                       done_q;
  bol_pkg::res_t              res_q;
  bol_pkg::res_t              res_d;
  bol_pkg::cell_ctl_t         ctl;
  logic [bol_pkg::POS_W-1:0]  pos_fix;
  logic [bol_pkg::POS_W-1:0]  pidx;
  logic [bol_pkg::CMP_W-1:0]  pidx_w;
  logic [bol_pkg::CMP_W-1:0]  cnt_w;
  logic                       full;
  logic                       empty;
  logic                       head_tie;
  logic                       rvalid;
  bol_pkg::status_e           status;

  bol_pkg::elem_t             data [bol_pkg::CAPACITY];
  logic                       run  [bol_pkg::CAPACITY+1];
  bol_pkg::elem_t             rem  [bol_pkg::CAPACITY+1];

  assign busy    = 1'b0;
  assign accept  = start & ~busy;
  assign pos_fix = (cmd_i.position == '0) ? bol_pkg::POS_W'(1) : cmd_i.position;
  assign pidx    = pos_fix - bol_pkg::POS_W'(1);
  assign pidx_w  = bol_pkg::CMP_W'(pidx);
  assign cnt_w   = bol_pkg::CMP_W'(count_q);
  assign full    = count_q >= bol_pkg::CNT_W'(bol_pkg::CAPACITY);
  assign empty   = count_q == '0;
  assign head_tie = !empty && (data[0] == cmd_i.value);

  always_comb begin
    ctl.op    = bol_pkg::OP_NONE;
    ctl.tgt   = '0;
    ctl.value = cmd_i.value;
    ctl.count = count_q;
    count_d   = count_q;
    status    = bol_pkg::ST_OK;
    rvalid    = 1'b0;
    if (accept) begin
      unique case (cmd_i.command)
        bol_pkg::CMD_INS_POS, bol_pkg::CMD_INS_TAIL, bol_pkg::CMD_INS_SORT: begin
          if (full) begin
            status = bol_pkg::ST_FULL;
          end else begin
            count_d = count_q + 1'b1;
            if (cmd_i.command == bol_pkg::CMD_INS_POS) begin
              ctl.op  = bol_pkg::OP_INS_POS;
              ctl.tgt = (pidx_w > cnt_w) ? bol_pkg::IDX_W'(count_q)
                                         : bol_pkg::IDX_W'(pidx);
            end else if (cmd_i.command == bol_pkg::CMD_INS_TAIL) begin
              ctl.op  = bol_pkg::OP_INS_POS;
              ctl.tgt = bol_pkg::IDX_W'(count_q);
            end else if (head_tie) begin
              ctl.op  = bol_pkg::OP_INS_POS;
              ctl.tgt = bol_pkg::IDX_W'(1);
            end else begin
              ctl.op  = bol_pkg::OP_INS_SORT;
            end
          end
        end
        bol_pkg::CMD_DEL_POS, bol_pkg::CMD_DEL_TAIL: begin
          if (empty) begin
            status = bol_pkg::ST_EMPTY;
          end else begin
            count_d = count_q - 1'b1;
            rvalid  = 1'b1;
            ctl.op  = bol_pkg::OP_DEL;
            if ((cmd_i.command == bol_pkg::CMD_DEL_POS) && (pidx_w < cnt_w)) begin
              ctl.tgt = bol_pkg::IDX_W'(pidx);
            end else begin
              ctl.tgt = bol_pkg::IDX_W'(count_q - 1'b1);
            end
          end
        end
        default: status = bol_pkg::ST_OK;
      endcase
    end
  end

  assign run[0] = 1'b1;
  assign rem[0] = '0;

  for (genvar i = 0; i < bol_pkg::CAPACITY; i++) begin : g_cell
    bol_pkg::elem_t left;
    bol_pkg::elem_t right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = data[i-1];
    end
    if (i == bol_pkg::CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = data[i+1];
    end
    bol_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .slot_i  (bol_pkg::IDX_W'(i)),
      .left_i  (left),
      .right_i (right),
      .run_i   (run[i]),
      .rem_i   (rem[i]),
      .data_o  (data[i]),
      .run_o   (run[i+1]),
      .rem_o   (rem[i+1])
    );
  end

  always_comb begin
    res_d.removed_value = rem[bol_pkg::CAPACITY];
    res_d.removed_valid = rvalid;
    res_d.status        = status;
    res_d.element_count = 6'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("result strobe missing after accepted word");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= bol_pkg::CNT_W'(bol_pkg::CAPACITY))
    else $error("element count above capacity");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_o.status == bol_pkg::ST_FULL)
      |-> count_q == bol_pkg::CNT_W'(bol_pkg::CAPACITY))
    else $error("full status with room left");

  a_del_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && rvalid |=> count_q == $past(count_q) - 1'b1)
    else $error("delete did not shrink the list");

endmodule

[tb/bol_checker.sv]
// checker for the bounded ordered list: tracks the list, predicts each result word and compares
`timescale 1ns / 100ps

module bol_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_i,
  input  bol_pkg::cmd_t cmd_i,
  input  logic          done_i,
  input  bol_pkg::res_t result_i,
  output int unsigned   fail_count_o,
  output int unsigned   pending_o
);
  import bol_pkg::*;

  elem_t       list_q[$];
  res_t        expected_q[$];
  int unsigned fail_count;

  initial begin
    fail_count   = 0;
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic res_t apply_command(cmd_t word);
    res_t r;
    int   slot;
    int   pos;
    int   len;
    r    = '0;
    len  = list_q.size();
    pos  = (word.position == '0) ? 1 : int'(word.position);
    slot = 0;
    case (word.command)
      CMD_INS_POS, CMD_INS_TAIL, CMD_INS_SORT: begin
        if (len >= int'(CAPACITY)) begin
          r.status = ST_FULL;
        end else begin
          if (word.command == CMD_INS_POS) begin
            slot = (pos - 1 > len) ? len : pos - 1;
          end else if (word.command == CMD_INS_TAIL) begin
            slot = len;
          end else begin
            while (slot < len && list_q[slot] < word.value) slot++;
            // equal head keeps its place, new value goes second
            if (slot == 0 && len > 0 && list_q[0] == word.value) slot = 1;
          end
          list_q.insert(slot, word.value);
        end
      end
      CMD_DEL_POS, CMD_DEL_TAIL: begin
        if (len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (word.command == CMD_DEL_POS && pos - 1 < len) slot = pos - 1;
          else slot = len - 1;
          r.removed_value = list_q[slot];
          r.removed_valid = 1'b1;
          list_q.delete(slot);
        end
      end
      default: ;
    endcase
    r.element_count = 6'(list_q.size());
    return r;
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (start_i && busy_i === 1'b0) expected_q.push_back(apply_command(cmd_i));
      if (done_i === 1'b1) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: result word with nothing expected: val=%0d valid=%0b status=%0d count=%0d",
                   $time, result_i.removed_value, result_i.removed_valid, result_i.status,
                   result_i.element_count);
        end else begin
          want = expected_q.pop_front();
          if (result_i !== want) begin
            fail_count++;
            $display("%0t: mismatch expected val=%0d valid=%0b status=%0d count=%0d",
                     $time, want.removed_value, want.removed_valid, want.status,
                     want.element_count);
            $display("%0t:          actual   val=%0d valid=%0b status=%0d count=%0d",
                     $time, result_i.removed_value, result_i.removed_valid, result_i.status,
                     result_i.element_count);
          end
        end
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= expected_q.size();
  end

endmodule

[tb/tb_bounded_ordered_list_core.sv]
// testbench top for the bounded ordered list: clock, reset, command stimulus and verdict
`timescale 1ns / 100ps

module tb_bounded_ordered_list_core;
  import bol_pkg::*;

  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_MID   = 3'd6;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
  localparam int         RANDOM_WORDS    = 600;

  typedef enum int {PH_FILL, PH_FILL_SORTED, PH_DRAIN, PH_CHURN} phase_e;

  logic        clk_i = 1'b0;
  logic        rst_n;
  logic        start;
  cmd_t        cmd;
  logic        busy;
  logic        done;
  res_t        result;
  int unsigned fail_count;
  int unsigned pending;

  always #10 clk_i = ~clk_i;

  bounded_ordered_list_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_n),
    .start   (start),
    .cmd_i   (cmd),
    .busy    (busy),
    .done_o  (done),
    .result_o(result)
  );

  bol_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_i      (busy),
    .cmd_i       (cmd),
    .done_i      (done),
    .result_i    (result),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  task automatic send_word(logic [2:0] op, elem_t v, logic [POS_W-1:0] p);
    start <= 1'b1;
    cmd   <= '{command: op, value: v, position: p};
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic int draw_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  function automatic elem_t draw_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return elem_t'($urandom_range(0, 6)) - 3;
    if (r < 50) begin
      case ($urandom_range(0, 4))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return -1;
        3:       return 0;
        default: return 1;
      endcase
    end
    return elem_t'($urandom);
  endfunction

  function automatic logic [POS_W-1:0] draw_position();
    if ($urandom_range(0, 99) < 70) return POS_W'($urandom_range(0, 34));
    return POS_W'($urandom_range(0, 63));
  endfunction

  function automatic logic [2:0] draw_command(phase_e ph);
    int r;
    int ins_share;
    r = $urandom_range(0, 99);
    if (r < 3) return 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    case (ph)
      PH_FILL, PH_FILL_SORTED: ins_share = 90;
      PH_DRAIN:                ins_share = 10;
      default:                 ins_share = 50;
    endcase
    if ($urandom_range(0, 99) < ins_share) begin
      if (ph == PH_FILL_SORTED) return CMD_INS_SORT;
      case ($urandom_range(0, 2))
        0:       return CMD_INS_POS;
        1:       return CMD_INS_TAIL;
        default: return CMD_INS_SORT;
      endcase
    end
    return ($urandom_range(0, 1) == 0) ? CMD_DEL_POS : CMD_DEL_TAIL;
  endfunction

  initial begin
    phase_e ph;
    int     sent;
    int     run;
    bit     quiet;
    start = 1'b0;
    cmd   = '0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // empty list, position zero, positions beyond the length, head ties, extremes
    send_word(CMD_DEL_TAIL, 5, 1);                 pause(draw_gap(0));
    send_word(CMD_DEL_POS, -5, 5);                 pause(draw_gap(0));
    send_word(CMD_INS_TAIL, 0, 0);                 pause(draw_gap(0));
    send_word(CMD_INS_POS, -1, 0);                 pause(draw_gap(0));
    send_word(CMD_INS_POS, 32'sh7fff_ffff, 63);    pause(draw_gap(0));
    send_word(CMD_INS_POS, 32'sh8000_0000, 2);     pause(draw_gap(0));
    send_word(CMD_INS_SORT, -1, 0);                pause(draw_gap(0));
    send_word(CMD_INS_SORT, 32'sh8000_0000, 1);    pause(draw_gap(0));
    send_word(CMD_INS_SORT, 32'sh7fff_ffff, 1);    pause(draw_gap(0));
    send_word(CMD_INS_SORT, 5, 1);                 pause(draw_gap(0));
    send_word(CMD_DEL_TAIL, 0, 0);                 pause(draw_gap(0));
    send_word(CMD_DEL_TAIL, 0, 0);                 pause(draw_gap(0));
    send_word(CMD_INS_SORT, 1000, 1);              pause(draw_gap(0));
    send_word(CMD_SPARE_FIRST, 32'sh7fff_ffff, 63); pause(draw_gap(0));
    send_word(CMD_SPARE_MID, -7, 1);               pause(draw_gap(0));
    send_word(CMD_SPARE_LAST, 32'sh8000_0000, 0);  pause(draw_gap(0));
    send_word(CMD_DEL_POS, 0, 0);                  pause(draw_gap(0));
    send_word(CMD_DEL_POS, 0, 63);                 pause(draw_gap(0));
    send_word(CMD_DEL_POS, 0, 2);                  pause(draw_gap(0));
    send_word(CMD_DEL_TAIL, 0, 32);                pause(draw_gap(0));

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      case ($urandom_range(0, 3))
        0:       ph = PH_FILL;
        1:       ph = PH_FILL_SORTED;
        2:       ph = PH_DRAIN;
        default: ph = PH_CHURN;
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      run   = $urandom_range(30, 60);
      repeat (run) begin
        send_word(draw_command(ph), draw_value(), draw_position());
        pause(draw_gap(quiet));
        sent++;
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[bounded_ordered_list_core.f]
hw/rtl/bol_pkg.sv
hw/rtl/bol_cell.sv
hw/rtl/bounded_ordered_list_core.sv
tb/bol_checker.sv
tb/tb_bounded_ordered_list_core.sv
